// ===== sv/stq_pkg.sv =====
// Shared codes, widths and types of the sorted timer queue.
`default_nettype none

package stq_pkg;

  // Sizing defaults
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  // Field widths of the stream payloads
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int REQ_W    = 2;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Input tdata layout: timer_id, new_expire, now_time
  localparam int IN_ID_LSB  = 0;
  localparam int IN_EXP_LSB = IN_ID_LSB + ID_W;
  localparam int IN_NOW_LSB = IN_EXP_LSB + TIME_W;
  localparam int IN_TDATA_W = ((IN_NOW_LSB + TIME_W + 7) / 8) * 8;

  // Output tdata layout: result_id, status, occupancy
  localparam int OUT_ID_LSB  = 0;
  localparam int OUT_ST_LSB  = OUT_ID_LSB + ID_W;
  localparam int OUT_OCC_LSB = OUT_ST_LSB + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_OCC_LSB + OCC_W + 7) / 8) * 8;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request codes
  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_ADJUST = 2'd2;
  localparam req_t REQ_TICK   = 2'd3;

  // Result kinds
  localparam kind_t KIND_ACK     = 2'd0;
  localparam kind_t KIND_EXPIRED = 2'd1;
  localparam kind_t KIND_NONE    = 2'd2;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_DUP       = 2'd3;

endpackage

`default_nettype wire

// ===== sv/sorted_timer_queue_top.sv =====
// Sorted timer queue: sequencer over one entry RAM kept in ascending expiry order.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser req_type; tdata timer_id, new_expire,
//          |     |                    | now_time
//  m_*     | out | m_tvalid/m_tready  | tuser result_kind; tdata result_id, status,
//          |     |                    | occupancy; tlast last_of_run
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Each entry scanned or moved takes a read, then a compare or write back, on the single
// RAM read port, so a request holds s_tready low while the sequencer walks the table.
// A stalled m_tready holds the sequencer only where it has a beat to load.
// Synchronous active-high reset empties the table; no clearing pass is needed.
`default_nettype none

module sorted_timer_queue_top
  import stq_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [7:0] timer_id, [39:8] new_expire, [71:40] now_time
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] req_type
  input  wire logic [REQ_W-1:0]       s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [7:0] result_id, [9:8] status, [14:10] occupancy, [15] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // [1:0] result_kind
  output logic [KIND_W-1:0]           m_tuser,
  output logic                        m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = TIME_W + ID_BITS;

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FIND_RD = 5'd1;
  localparam logic [4:0] S_FIND_CK = 5'd2;
  localparam logic [4:0] S_DECIDE  = 5'd3;
  localparam logic [4:0] S_RM_RD   = 5'd4;
  localparam logic [4:0] S_RM_WR   = 5'd5;
  localparam logic [4:0] S_INS_RD  = 5'd6;
  localparam logic [4:0] S_INS_CK  = 5'd7;
  localparam logic [4:0] S_SH_RD   = 5'd8;
  localparam logic [4:0] S_SH_WR   = 5'd9;
  localparam logic [4:0] S_ACK     = 5'd10;
  localparam logic [4:0] S_TK_RD   = 5'd11;
  localparam logic [4:0] S_TK_CK   = 5'd12;
  localparam logic [4:0] S_TK_END  = 5'd13;
  localparam logic [4:0] S_POP_RD  = 5'd14;
  localparam logic [4:0] S_POP_OUT = 5'd15;
  localparam logic [4:0] S_CP_RD   = 5'd16;
  localparam logic [4:0] S_CP_WR   = 5'd17;

  logic [4:0]         state;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      k_cnt;
  logic               found;
  req_t               req_r;
  logic [ID_BITS-1:0] id_r;
  logic [TIME_W-1:0]  exp_r;
  logic [TIME_W-1:0]  now_r;
  kind_t              kind_r;
  status_t            st_r;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;
  logic [AW-1:0]      rd_addr;
  logic [EW-1:0]      rd_data;
  logic [ID_BITS-1:0] rd_id;
  logic [TIME_W-1:0]  rd_exp;

  logic [SW-1:0]      idx_p1;
  logic [SW-1:0]      idx_m1;
  logic [SW-1:0]      idx_pk;
  logic [SW-1:0]      cnt_x;
  logic [CW-1:0]      cnt_left;
  logic               out_free;
  logic               out_load;
  logic               in_fire;
  logic [OUT_TDATA_W-1:0] ack_word;
  logic [OUT_TDATA_W-1:0] pop_word;

  assign rd_id    = rd_data[ID_BITS-1:0];
  assign rd_exp   = rd_data[ID_BITS +: TIME_W];
  assign idx_p1   = {1'b0, idx} + SW'(1);
  assign idx_m1   = {1'b0, idx} - SW'(1);
  assign idx_pk   = {1'b0, idx} + {1'b0, k_cnt};
  assign cnt_x    = {1'b0, cnt};
  assign cnt_left = cnt - k_cnt;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == S_ACK) || (state == S_POP_OUT));
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // Result words for an acknowledge and for an expired entry
  always_comb begin
    ack_word = '0;
    ack_word[OUT_ID_LSB +: ID_W]     = ID_W'(id_r);
    ack_word[OUT_ST_LSB +: STATUS_W] = st_r;
    ack_word[OUT_OCC_LSB +: OCC_W]   = OCC_W'(cnt);
    pop_word = '0;
    pop_word[OUT_ID_LSB +: ID_W]     = ID_W'(rd_id);
    pop_word[OUT_ST_LSB +: STATUS_W] = ST_OK;
    pop_word[OUT_OCC_LSB +: OCC_W]   = OCC_W'(cnt_left);
  end

  // Read address follows the state: neighbor of idx for shifts, idx+k for compaction
  always_comb begin
    unique case (state)
      S_RM_RD, S_RM_WR: rd_addr = idx_p1[AW-1:0];
      S_SH_RD, S_SH_WR: rd_addr = idx_m1[AW-1:0];
      S_CP_RD, S_CP_WR: rd_addr = idx_pk[AW-1:0];
      default:          rd_addr = idx[AW-1:0];
    endcase
  end

  // Write port: copy the entry just read, or drop the new entry into its slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_RM_WR, S_SH_WR, S_CP_WR: wr_en = 1'b1;
      S_SH_RD: begin
        if (idx == pos) begin
          wr_en   = 1'b1;
          wr_data = {exp_r, id_r};
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  stq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      cnt      <= '0;
      k_cnt    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Output valid: set on a load, cleared once the beat is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_r  <= s_tuser;
            id_r   <= ID_BITS'(s_tdata[IN_ID_LSB +: ID_W]);
            exp_r  <= s_tdata[IN_EXP_LSB +: TIME_W];
            now_r  <= s_tdata[IN_NOW_LSB +: TIME_W];
            kind_r <= KIND_ACK;
            st_r   <= ST_OK;
            found  <= 1'b0;
            idx    <= '0;
            state  <= (s_tuser == REQ_TICK) ? S_TK_RD : S_FIND_RD;
          end
        end

        // Search by id
        S_FIND_RD: state <= (idx == cnt) ? S_DECIDE : S_FIND_CK;
        S_FIND_CK: begin
          if (rd_id == id_r) begin
            found <= 1'b1;
            pos   <= idx;
            state <= S_DECIDE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FIND_RD;
          end
        end

        S_DECIDE: begin
          priority if (req_r == REQ_ADD) begin
            priority if (found) begin
              st_r  <= ST_DUP;
              state <= S_ACK;
            end else if (cnt == CW'(DEPTH)) begin
              st_r  <= ST_FULL;
              state <= S_ACK;
            end else begin
              idx   <= '0;
              state <= S_INS_RD;
            end
          end else if (!found) begin
            st_r  <= ST_NOT_FOUND;
            state <= S_ACK;
          end else begin
            idx   <= pos;
            state <= S_RM_RD;
          end
        end

        // Close the gap at pos by moving later entries up
        S_RM_RD: begin
          if (idx_p1 >= cnt_x) begin
            cnt <= cnt - CW'(1);
            if (req_r == REQ_ADJUST) begin
              idx   <= '0;
              state <= S_INS_RD;
            end else begin
              state <= S_ACK;
            end
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          idx   <= idx + CW'(1);
          state <= S_RM_RD;
        end

        // Find the first entry that expires strictly later
        S_INS_RD: begin
          if (idx == cnt) begin
            pos   <= idx;
            state <= S_SH_RD;
          end else begin
            state <= S_INS_CK;
          end
        end
        S_INS_CK: begin
          if (rd_exp > exp_r) begin
            pos   <= idx;
            idx   <= cnt;
            state <= S_SH_RD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_INS_RD;
          end
        end

        // Open a slot at pos from the tail down, then write the new entry
        S_SH_RD: begin
          if (idx == pos) begin
            cnt   <= cnt + CW'(1);
            state <= S_ACK;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx   <= idx - CW'(1);
          state <= S_SH_RD;
        end

        S_ACK: begin
          if (out_free) begin
            m_tdata  <= ack_word;
            m_tuser  <= kind_r;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end

        // Count the expired prefix
        S_TK_RD: state <= (idx == cnt) ? S_TK_END : S_TK_CK;
        S_TK_CK: begin
          if (rd_exp <= now_r) begin
            idx   <= idx + CW'(1);
            state <= S_TK_RD;
          end else begin
            state <= S_TK_END;
          end
        end
        S_TK_END: begin
          k_cnt <= idx;
          if (idx == '0) begin
            kind_r <= KIND_NONE;
            state  <= S_ACK;
          end else begin
            idx   <= '0;
            state <= S_POP_RD;
          end
        end

        // One beat per expired entry, head first
        S_POP_RD: state <= S_POP_OUT;
        S_POP_OUT: begin
          if (out_free) begin
            m_tdata  <= pop_word;
            m_tuser  <= KIND_EXPIRED;
            m_tlast  <= (idx == k_cnt - CW'(1));
            if (idx == k_cnt - CW'(1)) begin
              idx   <= '0;
              state <= S_CP_RD;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_POP_RD;
            end
          end
        end

        // Move the survivors down by k
        S_CP_RD: begin
          if (idx_pk >= cnt_x) begin
            cnt   <= cnt_left;
            state <= S_IDLE;
          end else begin
            state <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          idx   <= idx + CW'(1);
          state <= S_CP_RD;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= cnt)
    else $error("walk index past the last entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != S_IDLE)
    else $error("sequencer idle right after taking a request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("result beat changed while stalled");

endmodule

`default_nettype wire

// ===== sv/stq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timer_queue_top: directed cases, then random traffic.

module tb;
  import stq_pkg::*;

  localparam int WATCHDOG_NS  = 5_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int DRAIN_LIMIT  = 50_000;
  localparam int REPORT_MAX   = 10;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_BITS_DEF) - 1);

  // One result beat as the checker sees it
  typedef struct packed {
    logic [ID_W-1:0]  id;
    kind_t            kind;
    status_t          status;
    logic             last;
    logic [OCC_W-1:0] occ;
  } timer_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   m_tlast;

  // Shadow copy of the timer list, sorted by ascending expiry
  logic [TIME_W-1:0] tbl_expiry [DEPTH_DEF];
  logic [ID_W-1:0]   tbl_ident  [DEPTH_DEF];
  int                tbl_count = 0;

  timer_reply_t owed_replies[$];
  int           err_cnt = 0;
  bit           no_idle = 1'b0;
  int unsigned  ready_hold = 0;
  int unsigned  stall_draw;
  timer_reply_t got_reply;
  timer_reply_t want_reply;

  sorted_timer_queue_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Close the gap at pos, shifting later entries up
  function automatic void tbl_remove(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_expiry[i] = tbl_expiry[i + 1];
      tbl_ident[i]  = tbl_ident[i + 1];
    end
    tbl_count--;
  endfunction

  // Insert behind every entry that expires at or before exp
  function automatic void tbl_insert(logic [ID_W-1:0] id, logic [TIME_W-1:0] exp);
    int pos;
    pos = 0;
    while (pos < tbl_count && tbl_expiry[pos] <= exp) pos++;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_expiry[i] = tbl_expiry[i - 1];
      tbl_ident[i]  = tbl_ident[i - 1];
    end
    tbl_expiry[pos] = exp;
    tbl_ident[pos]  = id;
    tbl_count++;
  endfunction

  // Update the shadow list for one request and queue the beats it must produce
  function automatic void apply_timer_request(req_t req, logic [ID_W-1:0] raw_id,
                                              logic [TIME_W-1:0] exp,
                                              logic [TIME_W-1:0] now);
    logic [ID_W-1:0] id;
    int              pos;
    status_t         st;
    timer_reply_t    batch[$];
    id = raw_id & ID_MASK;
    if (req == REQ_TICK) begin
      // pop everything due from the head
      while (tbl_count > 0 && tbl_expiry[0] <= now) begin
        batch.push_back('{tbl_ident[0], KIND_EXPIRED, ST_OK, 1'b0, '0});
        tbl_remove(0);
      end
      if (batch.size() == 0) begin
        batch.push_back('{id, KIND_NONE, ST_OK, 1'b1, '0});
      end else begin
        batch[batch.size() - 1].last = 1'b1;
      end
    end else begin
      pos = -1;
      st  = ST_OK;
      for (int i = 0; i < tbl_count; i++) begin
        if (pos < 0 && tbl_ident[i] == id) pos = i;
      end
      if (req == REQ_ADD) begin
        // duplicate wins over full
        if (pos >= 0) st = ST_DUP;
        else if (tbl_count >= DEPTH_DEF) st = ST_FULL;
        else tbl_insert(id, exp);
      end else if (pos < 0) begin
        st = ST_NOT_FOUND;
      end else begin
        tbl_remove(pos);
        if (req == REQ_ADJUST) tbl_insert(id, exp);
      end
      batch.push_back('{id, KIND_ACK, st, 1'b1, '0});
    end
    // occupancy reflects the table after the whole request
    foreach (batch[k]) begin
      batch[k].occ = OCC_W'(tbl_count);
      owed_replies.push_back(batch[k]);
    end
  endfunction

  // Drive one request beat and wait for it to be taken
  task automatic send_request(req_t req, logic [ID_W-1:0] id,
                              logic [TIME_W-1:0] exp, logic [TIME_W-1:0] now);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    word = '0;
    word[IN_ID_LSB  +: ID_W]   = id;
    word[IN_EXP_LSB +: TIME_W] = exp;
    word[IN_NOW_LSB +: TIME_W] = now;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    apply_timer_request(req, id, exp, now);
  endtask

  // Result side: random backpressure, compare every beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (m_tvalid && m_tready) begin
      got_reply.id     = m_tdata[OUT_ID_LSB +: ID_W];
      got_reply.kind   = m_tuser;
      got_reply.status = m_tdata[OUT_ST_LSB +: STATUS_W];
      got_reply.last   = m_tlast;
      got_reply.occ    = m_tdata[OUT_OCC_LSB +: OCC_W];
      if (owed_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected beat id=%0d kind=%0d status=%0d",
                                got_reply.id, got_reply.kind, got_reply.status));
      end else begin
        want_reply = owed_replies.pop_front();
        if (got_reply !== want_reply) begin
          note_mismatch($sformatf({"beat mismatch (exp/got): id %0d/%0d kind %0d/%0d",
                                   " status %0d/%0d last %0d/%0d occ %0d/%0d"},
                                  want_reply.id, got_reply.id,
                                  want_reply.kind, got_reply.kind,
                                  want_reply.status, got_reply.status,
                                  want_reply.last, got_reply.last,
                                  want_reply.occ, got_reply.occ));
        end
      end
      stall_draw = no_idle ? 0 : $urandom_range(0, 4);
      ready_hold <= stall_draw;
      m_tready   <= (stall_draw == 0);
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready   <= (ready_hold == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Tick on an empty list at time zero
  task automatic test_idle_tick();
    send_request(REQ_TICK, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Fill to capacity with ties and extreme expiries, then hit duplicate and full
  task automatic test_fill();
    logic [TIME_W-1:0] exps [14] = '{100, 100, 100, 50, 200, 32'hFFFF_FFFF, 150,
                                      75, 300, 100, 1000, 500, 250, 7};
    send_request(REQ_ADD, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    for (int k = 0; k < 14; k++) begin
      send_request(REQ_ADD, 8'h40 + ID_W'(k), exps[k], 32'h0);
    end
    send_request(REQ_ADD, 8'h41, 32'd5, 32'h0);
    send_request(REQ_ADD, 8'h80, 32'd5, 32'h0);
  endtask

  // Delete and adjust of an id that is not held
  task automatic test_missing_ids();
    send_request(REQ_DELETE, 8'h81, 32'h0, 32'h0);
    send_request(REQ_ADJUST, 8'h82, 32'd10, 32'h0);
  endtask

  // Move one entry earlier, one later behind its ties, and delete one
  task automatic test_moves();
    send_request(REQ_ADJUST, 8'h40, 32'd2, 32'h0);
    send_request(REQ_ADJUST, 8'h00, 32'd100, 32'h0);
    send_request(REQ_DELETE, 8'h45, 32'h0, 32'h0);
  endtask

  // Tick with nothing due, a partial pop with ties, then pop everything
  task automatic test_expiry();
    send_request(REQ_TICK, 8'hFF, 32'h0, 32'd1);
    send_request(REQ_TICK, 8'h01, 32'h0, 32'd100);
    send_request(REQ_TICK, 8'h02, 32'h0, 32'hFFFF_FFFF);
  endtask

  // Mostly coherent traffic on a small id pool around a moving clock, plus noise
  task automatic test_random_traffic(int items, int add_pct, bit quiet);
    logic [ID_W-1:0]   pool_base;
    logic [TIME_W-1:0] now_mark;
    int                roll;
    no_idle   = quiet;
    pool_base = ID_W'($urandom());
    now_mark  = $urandom();
    // flush whatever the previous phase left behind
    send_request(REQ_TICK, ID_W'($urandom()), $urandom(), 32'hFFFF_FFFF);
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        send_request(REQ_ADD, pool_base + ID_W'($urandom_range(0, 23)),
                     now_mark + $urandom_range(0, 60), $urandom());
      end else if (roll < add_pct + 15) begin
        send_request(REQ_DELETE, pool_base + ID_W'($urandom_range(0, 23)),
                     $urandom(), $urandom());
      end else if (roll < add_pct + 30) begin
        send_request(REQ_ADJUST, pool_base + ID_W'($urandom_range(0, 23)),
                     now_mark + $urandom_range(0, 60), $urandom());
      end else if (roll < 95) begin
        now_mark += $urandom_range(0, 25);
        send_request(REQ_TICK, ID_W'($urandom()), $urandom(), now_mark);
      end else begin
        send_request(req_t'($urandom_range(0, 3)), ID_W'($urandom()),
                     $urandom(), $urandom());
      end
    end
  endtask

  // Sequence of tests, then drain and verdict
  initial begin
    int wait_cnt;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_tick();
    test_fill();
    test_missing_ids();
    test_moves();
    test_expiry();
    test_random_traffic(120, 40, 1'b1);
    test_random_traffic(130, 40, 1'b0);
    test_random_traffic(130, 60, 1'b0);
    test_random_traffic(120, 30, 1'b0);
    s_tvalid <= 1'b0;
    for (wait_cnt = 0; owed_replies.size() != 0 && wait_cnt < DRAIN_LIMIT; wait_cnt++) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $display("%0t: %0d predicted beats never arrived", $time, owed_replies.size());
      err_cnt += owed_replies.size();
    end
    if (err_cnt == 0) begin
      $display("** sorted_timer_queue_top: PASSED **");
    end else begin
      $display("** sorted_timer_queue_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("** sorted_timer_queue_top: FAILED **");
    $finish;
  end

endmodule
